>>> rtl/schlick_fresnel_reflectance_core_assert.svh
// Assertion macros shared by the Schlick Fresnel reflectance RTL.
`ifndef SCHLICK_FRESNEL_REFLECTANCE_CORE_ASSERT_SVH
`define SCHLICK_FRESNEL_REFLECTANCE_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define SFR_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sfr assertion failed");
`define SFR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sfr assertion failed");
`else
`define SFR_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define SFR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

>>> rtl/sfr_pkg.sv
// Types and constants of the Schlick Fresnel reflectance core.
package sfr_pkg;

    localparam logic [15:0] INDEX_ONE = 16'd4096;
    localparam logic [15:0] Q15_ONE = 16'd32768;
    localparam logic signed [33:0] DOT_MAX = 34'sd268435456;
    localparam logic signed [33:0] DOT_MIN = -34'sd268435456;

    localparam int DIV_NUM_W = 64;
    localparam int DIV_DEN_W = 34;
    localparam int DIV_QUOT_W = 33;
    localparam int SQRT_IN_W = 33;
    localparam int SQRT_OUT_W = 17;
    // Schlick exponent 5 takes four multiplies by x, starting from x itself.
    localparam int POW_STEPS = 4;

    typedef struct packed {
        logic signed [17:0] cos;
        logic               gt;
        logic               tir;
    } t_div_side;

    typedef struct packed {
        logic signed [17:0] cos;
        logic               gt;
        logic               tir;
        logic [30:0]        r0;
    } t_sqrt_side;

endpackage

>>> rtl/sfr_div.sv
// Pipelined restoring divider, one quotient bit per register stage.
module sfr_div #(
    parameter int N_W = 64,
    parameter int D_W = 34,
    parameter int Q_W = 33,
    parameter int S_W = 1
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  logic [N_W-1:0] i_num,
    input  logic [D_W-1:0] i_den,
    input  logic [S_W-1:0] i_side,
    output logic           o_valid,
    output logic [Q_W-1:0] o_quot,
    output logic [S_W-1:0] o_side
);

    localparam int C_W = (N_W > D_W + Q_W) ? N_W : D_W + Q_W;

    logic [N_W-1:0] r_rem  [Q_W];
    logic [D_W-1:0] r_den  [Q_W];
    logic [Q_W-1:0] r_quot [Q_W];
    logic [S_W-1:0] r_side [Q_W];
    logic [Q_W-1:0] r_vld;

    wire [N_W-1:0] n_rem  [Q_W];
    wire [D_W-1:0] n_den  [Q_W];
    wire [Q_W-1:0] n_quot [Q_W];
    wire [S_W-1:0] n_side [Q_W];
    wire [Q_W-1:0] n_vld;

    for (genvar k = 0; k < Q_W; k++) begin : g_stage
        localparam int SH = Q_W - 1 - k;
        logic [N_W-1:0] w_rem;
        logic [D_W-1:0] w_den;
        logic [Q_W-1:0] w_quot;
        logic [S_W-1:0] w_side;
        logic           w_vld;
        logic [C_W-1:0] w_trial;
        logic           w_take;

        if (k == 0) begin : g_first
            assign w_rem  = i_num;
            assign w_den  = i_den;
            assign w_quot = '0;
            assign w_side = i_side;
            assign w_vld  = i_valid;
        end else begin : g_next
            assign w_rem  = r_rem[k-1];
            assign w_den  = r_den[k-1];
            assign w_quot = r_quot[k-1];
            assign w_side = r_side[k-1];
            assign w_vld  = r_vld[k-1];
        end

        assign w_trial   = C_W'(w_den) << SH;
        assign w_take    = C_W'(w_rem) >= w_trial;
        assign n_rem[k]  = w_take ? N_W'(C_W'(w_rem) - w_trial) : w_rem;
        assign n_den[k]  = w_den;
        assign n_quot[k] = w_quot | (w_take ? (Q_W'(1) << SH) : '0);
        assign n_side[k] = w_side;
        assign n_vld[k]  = w_vld;
    end

    always_ff @(posedge i_clk) begin
        r_rem  <= n_rem;
        r_den  <= n_den;
        r_quot <= n_quot;
        r_side <= n_side;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    assign o_valid = r_vld[Q_W-1];
    assign o_quot  = r_quot[Q_W-1];
    assign o_side  = r_side[Q_W-1];

endmodule

>>> rtl/sfr_sqrt.sv
// Pipelined integer square root (floor), one result bit per register stage.
module sfr_sqrt #(
    parameter int V_W = 33,
    parameter int R_W = 17,
    parameter int S_W = 1
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  logic [V_W-1:0] i_value,
    input  logic [S_W-1:0] i_side,
    output logic           o_valid,
    output logic [R_W-1:0] o_root,
    output logic [S_W-1:0] o_side
);

    localparam int T_W = V_W + 2;

    logic [V_W-1:0] r_val  [R_W];
    logic [T_W-1:0] r_acc  [R_W];
    logic [S_W-1:0] r_side [R_W];
    logic [R_W-1:0] r_vld;

    wire [V_W-1:0] n_val  [R_W];
    wire [T_W-1:0] n_acc  [R_W];
    wire [S_W-1:0] n_side [R_W];
    wire [R_W-1:0] n_vld;

    for (genvar k = 0; k < R_W; k++) begin : g_stage
        localparam int SH = 2 * (R_W - 1 - k);
        localparam logic [T_W-1:0] BIT = T_W'(1) << SH;
        logic [V_W-1:0] w_val;
        logic [T_W-1:0] w_acc;
        logic [S_W-1:0] w_side;
        logic           w_vld;
        logic [T_W-1:0] w_trial;
        logic           w_take;

        if (k == 0) begin : g_first
            assign w_val  = i_value;
            assign w_acc  = '0;
            assign w_side = i_side;
            assign w_vld  = i_valid;
        end else begin : g_next
            assign w_val  = r_val[k-1];
            assign w_acc  = r_acc[k-1];
            assign w_side = r_side[k-1];
            assign w_vld  = r_vld[k-1];
        end

        assign w_trial   = w_acc + BIT;
        assign w_take    = T_W'(w_val) >= w_trial;
        assign n_val[k]  = w_take ? V_W'(T_W'(w_val) - w_trial) : w_val;
        assign n_acc[k]  = w_take ? ((w_acc >> 1) + BIT) : (w_acc >> 1);
        assign n_side[k] = w_side;
        assign n_vld[k]  = w_vld;
    end

    always_ff @(posedge i_clk) begin
        r_val  <= n_val;
        r_acc  <= n_acc;
        r_side <= n_side;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    assign o_valid = r_vld[R_W-1];
    assign o_root  = r_acc[R_W-1][R_W-1:0];
    assign o_side  = r_side[R_W-1];

endmodule

>>> rtl/schlick_fresnel_reflectance_core.sv
// Top level of the Schlick Fresnel reflectance pipeline.
//
// An item (eye and normal vectors in signed Q2.14, incident and transmitting
// indices in unsigned Q4.12) is taken at a rising edge with start high and
// busy low. busy is never raised, so one item may enter in every cycle.
// Each item gives one result: o_reflectance in unsigned Q1.15 and the flag
// o_total_internal, shown for exactly one cycle with o_valid high.
// Throughput is one item per cycle. The depth is set by the two dividers
// (33 stages, one quotient bit each) and the square root that follows them
// (17 stages, one root bit each); the rest is the dot product, the index
// squares, four power multiplies and the final blend.
// Items leave in the order they entered. The receiver cannot stall, so no
// result is ever held back. Synchronous reset clears every valid bit and
// drops items in flight; there is no other state.
module schlick_fresnel_reflectance_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [15:0] i_eye_x,
    input  logic signed [15:0] i_eye_y,
    input  logic signed [15:0] i_eye_z,
    input  logic signed [15:0] i_normal_x,
    input  logic signed [15:0] i_normal_y,
    input  logic signed [15:0] i_normal_z,
    input  logic [15:0]        i_index_from,
    input  logic [15:0]        i_index_to,
    output logic               o_valid,
    output logic [15:0]        o_reflectance,
    output logic               o_total_internal
);

    import sfr_pkg::*;

`include "schlick_fresnel_reflectance_core_assert.svh"

    // Stage 1: products and index clamp.
    logic signed [31:0] r_s1_p0, r_s1_p1, r_s1_p2;
    logic [15:0]        r_s1_n1, r_s1_n2;
    logic               r_s1_vld;
    // Stage 2: clamped dot product and index sums.
    logic signed [29:0] r_s2_dot;
    logic [15:0]        r_s2_n1, r_s2_n2, r_s2_diff;
    logic [16:0]        r_s2_sum;
    logic               r_s2_gt, r_s2_vld;
    // Stage 3: cosine and squares.
    logic signed [17:0] r_s3_cos;
    logic [31:0]        r_s3_n1sq, r_s3_n2sq, r_s3_diff2;
    logic [33:0]        r_s3_sum2;
    logic               r_s3_gt, r_s3_vld;
    // Stage 4: one minus cosine squared.
    logic signed [17:0] r_s4_cos;
    logic [32:0]        r_s4_omc2;
    logic [31:0]        r_s4_n1sq, r_s4_n2sq, r_s4_diff2;
    logic [33:0]        r_s4_sum2;
    logic               r_s4_gt, r_s4_vld;
    // Stage 5: n1 squared times the sine squared.
    logic signed [17:0] r_s5_cos;
    logic [63:0]        r_s5_prod;
    logic [31:0]        r_s5_n2sq, r_s5_diff2;
    logic [33:0]        r_s5_sum2;
    logic               r_s5_gt, r_s5_vld;

    logic signed [33:0] w_dot;
    logic signed [30:0] w_u;
    logic signed [18:0] w_cos19;
    logic signed [35:0] w_c2;
    logic [64:0]        w_prod;

    assign busy = 1'b0;

    assign w_dot   = 34'(r_s1_p0) + 34'(r_s1_p1) + 34'(r_s1_p2);
    assign w_u     = 31'(r_s2_dot) + 31'sd268437504;
    assign w_cos19 = $signed({1'b0, w_u[29:12]}) - 19'sd65536;
    assign w_c2    = r_s3_cos * r_s3_cos;
    assign w_prod  = r_s4_n1sq * r_s4_omc2;

    always_ff @(posedge i_clk) begin
        r_s1_p0 <= i_eye_x * i_normal_x;
        r_s1_p1 <= i_eye_y * i_normal_y;
        r_s1_p2 <= i_eye_z * i_normal_z;
        r_s1_n1 <= (i_index_from < INDEX_ONE) ? INDEX_ONE : i_index_from;
        r_s1_n2 <= (i_index_to < INDEX_ONE) ? INDEX_ONE : i_index_to;

        if (w_dot > DOT_MAX) begin
            r_s2_dot <= 30'(DOT_MAX);
        end else if (w_dot < DOT_MIN) begin
            r_s2_dot <= 30'(DOT_MIN);
        end else begin
            r_s2_dot <= 30'(w_dot);
        end
        r_s2_n1   <= r_s1_n1;
        r_s2_n2   <= r_s1_n2;
        r_s2_gt   <= r_s1_n1 > r_s1_n2;
        r_s2_diff <= (r_s1_n1 > r_s1_n2) ? (r_s1_n1 - r_s1_n2) : (r_s1_n2 - r_s1_n1);
        r_s2_sum  <= 17'(r_s1_n1) + 17'(r_s1_n2);

        r_s3_cos   <= w_cos19[17:0];
        r_s3_n1sq  <= r_s2_n1 * r_s2_n1;
        r_s3_n2sq  <= r_s2_n2 * r_s2_n2;
        r_s3_diff2 <= r_s2_diff * r_s2_diff;
        r_s3_sum2  <= r_s2_sum * r_s2_sum;
        r_s3_gt    <= r_s2_gt;

        r_s4_cos   <= r_s3_cos;
        r_s4_omc2  <= 33'h1_0000_0000 - w_c2[32:0];
        r_s4_n1sq  <= r_s3_n1sq;
        r_s4_n2sq  <= r_s3_n2sq;
        r_s4_diff2 <= r_s3_diff2;
        r_s4_sum2  <= r_s3_sum2;
        r_s4_gt    <= r_s3_gt;

        r_s5_cos   <= r_s4_cos;
        r_s5_prod  <= w_prod[63:0];
        r_s5_n2sq  <= r_s4_n2sq;
        r_s5_diff2 <= r_s4_diff2;
        r_s5_sum2  <= r_s4_sum2;
        r_s5_gt    <= r_s4_gt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
            r_s3_vld <= 1'b0;
            r_s4_vld <= 1'b0;
            r_s5_vld <= 1'b0;
        end else begin
            r_s1_vld <= start && !busy;
            r_s2_vld <= r_s1_vld;
            r_s3_vld <= r_s2_vld;
            r_s4_vld <= r_s3_vld;
            r_s5_vld <= r_s4_vld;
        end
    end

    // Both divisions run side by side; only the sine one carries the sideband.
    t_div_side                  w_div_side_in, w_div_side_out;
    logic [$bits(t_div_side)-1:0] w_div_side_vec;
    logic [DIV_QUOT_W-1:0]      w_sin2, w_r0q;
    logic                       w_sin_vld, w_r0_vld;

    assign w_div_side_in.cos = r_s5_cos;
    assign w_div_side_in.gt  = r_s5_gt;
    // Total internal reflection when the transmitted sine squared exceeds one.
    assign w_div_side_in.tir = r_s5_prod > {r_s5_n2sq, 32'h0};

    sfr_div #(
        .N_W (DIV_NUM_W),
        .D_W (DIV_DEN_W),
        .Q_W (DIV_QUOT_W),
        .S_W ($bits(t_div_side))
    ) u_div_sin (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_s5_vld),
        .i_num   (r_s5_prod),
        .i_den   (DIV_DEN_W'(r_s5_n2sq)),
        .i_side  (w_div_side_in),
        .o_valid (w_sin_vld),
        .o_quot  (w_sin2),
        .o_side  (w_div_side_vec)
    );

    sfr_div #(
        .N_W (DIV_NUM_W),
        .D_W (DIV_DEN_W),
        .Q_W (DIV_QUOT_W),
        .S_W (1)
    ) u_div_r0 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_s5_vld),
        .i_num   ({2'b00, r_s5_diff2, 30'h0}),
        .i_den   (r_s5_sum2),
        .i_side  (1'b0),
        .o_valid (w_r0_vld),
        .o_quot  (w_r0q),
        .o_side  ()
    );

    assign w_div_side_out = w_div_side_vec;

    t_sqrt_side                    w_sq_side_in, w_sq_side_out;
    logic [$bits(t_sqrt_side)-1:0] w_sq_side_vec;
    logic [SQRT_OUT_W-1:0]         w_root;
    logic                          w_sq_vld;

    assign w_sq_side_in.cos = w_div_side_out.cos;
    assign w_sq_side_in.gt  = w_div_side_out.gt;
    assign w_sq_side_in.tir = w_div_side_out.tir;
    assign w_sq_side_in.r0  = w_r0q[30:0];

    sfr_sqrt #(
        .V_W (SQRT_IN_W),
        .R_W (SQRT_OUT_W),
        .S_W ($bits(t_sqrt_side))
    ) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_sin_vld),
        .i_value (33'h1_0000_0000 - w_sin2),
        .i_side  (w_sq_side_in),
        .o_valid (w_sq_vld),
        .o_root  (w_root),
        .o_side  (w_sq_side_vec)
    );

    assign w_sq_side_out = w_sq_side_vec;

    // Stage A: pick the cosine in use and form x = 1 - cos.
    logic signed [18:0] w_cosv;
    logic [17:0]        r_a_x;
    logic [30:0]        r_a_r0;
    logic               r_a_tir, r_a_vld;

    assign w_cosv = w_sq_side_out.gt ? $signed({2'b00, w_root}) : 19'(w_sq_side_out.cos);

    always_ff @(posedge i_clk) begin
        r_a_x   <= 18'(19'sd65536 - w_cosv);
        r_a_r0  <= w_sq_side_out.r0;
        r_a_tir <= w_sq_side_out.gt && w_sq_side_out.tir;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else begin
            r_a_vld <= w_sq_vld;
        end
    end

    // Power stages: x^5 by four multiplies, each rounded back to Q.16.
    logic [21:0]          r_pw_p   [POW_STEPS];
    logic [17:0]          r_pw_x   [POW_STEPS];
    logic [30:0]          r_pw_r0  [POW_STEPS];
    logic [POW_STEPS-1:0] r_pw_tir;
    logic [POW_STEPS-1:0] r_pw_vld;

    wire [21:0]          n_pw_p   [POW_STEPS];
    wire [17:0]          n_pw_x   [POW_STEPS];
    wire [30:0]          n_pw_r0  [POW_STEPS];
    wire [POW_STEPS-1:0] n_pw_tir;
    wire [POW_STEPS-1:0] n_pw_vld;

    for (genvar k = 0; k < POW_STEPS; k++) begin : g_pow
        logic [21:0] w_p;
        logic [17:0] w_x;
        logic [30:0] w_r0;
        logic        w_tir, w_vld;
        logic [39:0] w_mul;

        if (k == 0) begin : g_first
            assign w_p   = 22'(r_a_x);
            assign w_x   = r_a_x;
            assign w_r0  = r_a_r0;
            assign w_tir = r_a_tir;
            assign w_vld = r_a_vld;
        end else begin : g_next
            assign w_p   = r_pw_p[k-1];
            assign w_x   = r_pw_x[k-1];
            assign w_r0  = r_pw_r0[k-1];
            assign w_tir = r_pw_tir[k-1];
            assign w_vld = r_pw_vld[k-1];
        end

        assign w_mul       = w_p * w_x + 40'd32768;
        assign n_pw_p[k]   = w_mul[37:16];
        assign n_pw_x[k]   = w_x;
        assign n_pw_r0[k]  = w_r0;
        assign n_pw_tir[k] = w_tir;
        assign n_pw_vld[k] = w_vld;
    end

    always_ff @(posedge i_clk) begin
        r_pw_p   <= n_pw_p;
        r_pw_x   <= n_pw_x;
        r_pw_r0  <= n_pw_r0;
        r_pw_tir <= n_pw_tir;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pw_vld <= '0;
        end else begin
            r_pw_vld <= n_pw_vld;
        end
    end

    // Stage C: (1 - R0) * x^5 in Q.30.
    logic [30:0] w_om;
    logic [52:0] w_tfull;
    logic [36:0] r_c_term;
    logic [30:0] r_c_r0;
    logic        r_c_tir, r_c_vld;

    assign w_om    = 31'h4000_0000 - r_pw_r0[POW_STEPS-1];
    assign w_tfull = w_om * r_pw_p[POW_STEPS-1];

    always_ff @(posedge i_clk) begin
        r_c_term <= w_tfull[52:16];
        r_c_r0   <= r_pw_r0[POW_STEPS-1];
        r_c_tir  <= r_pw_tir[POW_STEPS-1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_vld <= 1'b0;
        end else begin
            r_c_vld <= r_pw_vld[POW_STEPS-1];
        end
    end

    // Output stage: add, round to Q.15 and saturate at 1.0; total internal reflection forces 1.0.
    logic [37:0] w_total;
    logic [38:0] w_rnd;
    logic [23:0] w_res;

    assign w_total = 38'(r_c_r0) + 38'(r_c_term);
    assign w_rnd   = 39'(w_total) + 39'd16384;
    assign w_res   = w_rnd[38:15];

    always_ff @(posedge i_clk) begin
        if (r_c_tir || (w_res > 24'(Q15_ONE))) begin
            o_reflectance <= Q15_ONE;
        end else begin
            o_reflectance <= w_res[15:0];
        end
        o_total_internal <= r_c_tir;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= r_c_vld;
        end
    end

    `SFR_ASSERT_NEXT(a_enter, i_clk, i_rst_n, start && !busy, r_s1_vld)
    `SFR_ASSERT_IMPL(a_div_lockstep, i_clk, i_rst_n, 1'b1, w_sin_vld == w_r0_vld)
    `SFR_ASSERT_IMPL(a_tir_full, i_clk, i_rst_n, o_valid && o_total_internal, o_reflectance == Q15_ONE)
    `SFR_ASSERT_IMPL(a_saturate, i_clk, i_rst_n, o_valid, o_reflectance <= Q15_ONE)

endmodule
